// ===== rtl/cmbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cmbfs_pkg: shared definitions for the carrier mode best-fit selector
// Holds the default sizes, the opcode and result codes, the sequencer state
// type and the control and status bundles passed to the ranking unit.
// ----------------------------------------------------------------------------
package cmbfs_pkg;

   // Default table depth and dimension width.
   localparam int MODE_SLOTS_DEF = 16;
   localparam int DIM_BITS_DEF   = 16;

   // Fixed width of the slot field on the request channel.
   localparam int SLOT_BITS = 4;

   // Request opcodes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // How the returned mode was chosen.
   typedef enum logic [1:0] {
      HOW_EXACT = 2'd0,
      HOW_COVER = 2'd1,
      HOW_SCALE = 2'd2,
      HOW_NONE  = 2'd3
   } how_type;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } fsm_state_type;

   // Control from the scan sequencer to the ranking unit.
   typedef struct packed {
      logic start;   // clear the running choices for a new query
      logic take;    // a candidate slot is presented this cycle
      logic last;    // the presented candidate is the final slot
   } rank_ctl_type;

   // Status from the ranking unit back to the sequencer.
   typedef struct packed {
      logic done;    // the final candidate is ranked at this edge
      logic found;   // some usable mode has been seen
   } rank_stat_type;

endpackage

// ===== rtl/cmbfs_rank.sv =====
// ----------------------------------------------------------------------------
// cmbfs_rank: running best-mode selection for one query
// Takes candidate modes one by one and keeps the first exact match,
// the smallest covering mode and the mode of least downscale. The downscale
// order uses registered cross products, then a compare in the next cycle.
// ----------------------------------------------------------------------------
module cmbfs_rank #(
   parameter int DIM_BITS = cmbfs_pkg::DIM_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmbfs_pkg::rank_ctl_type  ctl,
   input  logic                     cand_use,
   input  logic                     cand_exact,
   input  logic                     cand_cover,
   input  logic [DIM_BITS-1:0]      cand_width,
   input  logic [DIM_BITS-1:0]      cand_height,
   input  logic [2*DIM_BITS-1:0]    cand_area,
   input  logic [2*DIM_BITS-1:0]    cand_num,
   output cmbfs_pkg::rank_stat_type stat,
   output cmbfs_pkg::how_type       sel_how,
   output logic [DIM_BITS-1:0]      sel_width,
   output logic [DIM_BITS-1:0]      sel_height
);
   import cmbfs_pkg::*;

   localparam int PW = 2 * DIM_BITS;
   localparam int XW = 4 * DIM_BITS;

   // Candidate stage.
   logic                c_v_ff;
   logic                c_last_ff;
   logic                c_use_ff;
   logic                c_exact_ff;
   logic                c_cover_ff;
   logic [DIM_BITS-1:0] c_w_ff;
   logic [DIM_BITS-1:0] c_h_ff;
   logic [PW-1:0]       c_area_ff;
   logic [PW-1:0]       c_num_ff;

   // Cross product stage.
   logic                x_v_ff;
   logic                x_last_ff;
   logic [XW-1:0]       lhs_ff;
   logic [XW-1:0]       rhs_ff;

   // Running choices.
   logic                have_exact_ff;
   logic                have_cover_ff;
   logic                have_scale_ff;
   logic [DIM_BITS-1:0] ex_w_ff;
   logic [DIM_BITS-1:0] ex_h_ff;
   logic [DIM_BITS-1:0] cv_w_ff;
   logic [DIM_BITS-1:0] cv_h_ff;
   logic [PW-1:0]       cv_area_ff;
   logic [DIM_BITS-1:0] sc_w_ff;
   logic [DIM_BITS-1:0] sc_h_ff;
   logic [PW-1:0]       sc_num_ff;
   logic [PW-1:0]       sc_den_ff;

   logic exact_take;
   logic cover_take;
   logic scale_take;

   // Control valids of the two stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff    <= 1'b0;
         c_last_ff <= 1'b0;
         x_v_ff    <= 1'b0;
         x_last_ff <= 1'b0;
      end else begin
         c_v_ff    <= ctl.take;
         c_last_ff <= ctl.take & ctl.last;
         x_v_ff    <= c_v_ff;
         x_last_ff <= c_last_ff;
      end
   end

   // Candidate payload; it holds until the next one arrives.
   always_ff @(posedge clock) begin
      if (ctl.take) begin
         c_use_ff   <= cand_use;
         c_exact_ff <= cand_exact;
         c_cover_ff <= cand_cover;
         c_w_ff     <= cand_width;
         c_h_ff     <= cand_height;
         c_area_ff  <= cand_area;
         c_num_ff   <= cand_num;
      end
   end

   // Cross products of the candidate ratio against the current best ratio.
   always_ff @(posedge clock) begin
      if (c_v_ff) begin
         lhs_ff <= XW'(c_num_ff) * XW'(sc_den_ff);
         rhs_ff <= XW'(sc_num_ff) * XW'(c_area_ff);
      end
   end

   // Update decisions for the three rules.
   always_comb begin
      exact_take = c_use_ff && c_exact_ff && !have_exact_ff;
      cover_take = c_use_ff && c_cover_ff && (!have_cover_ff || (c_area_ff < cv_area_ff));
      scale_take = c_use_ff && (!have_scale_ff || (lhs_ff < rhs_ff) ||
                               ((lhs_ff == rhs_ff) && (c_area_ff > sc_den_ff)));
   end

   // Found flags are cleared at the start of each query.
   always_ff @(posedge clock) begin
      if (reset) begin
         have_exact_ff <= 1'b0;
         have_cover_ff <= 1'b0;
         have_scale_ff <= 1'b0;
      end else if (ctl.start) begin
         have_exact_ff <= 1'b0;
         have_cover_ff <= 1'b0;
         have_scale_ff <= 1'b0;
      end else if (x_v_ff) begin
         if (exact_take) begin
            have_exact_ff <= 1'b1;
         end
         if (cover_take) begin
            have_cover_ff <= 1'b1;
         end
         if (scale_take) begin
            have_scale_ff <= 1'b1;
         end
      end
   end

   // Chosen mode payloads.
   always_ff @(posedge clock) begin
      if (x_v_ff) begin
         if (exact_take) begin
            ex_w_ff <= c_w_ff;
            ex_h_ff <= c_h_ff;
         end
         if (cover_take) begin
            cv_w_ff    <= c_w_ff;
            cv_h_ff    <= c_h_ff;
            cv_area_ff <= c_area_ff;
         end
         if (scale_take) begin
            sc_w_ff   <= c_w_ff;
            sc_h_ff   <= c_h_ff;
            sc_num_ff <= c_num_ff;
            sc_den_ff <= c_area_ff;
         end
      end
   end

   // Final choice in rule priority order.
   always_comb begin
      sel_how    = HOW_NONE;
      sel_width  = '0;
      sel_height = '0;
      if (have_exact_ff) begin
         sel_how    = HOW_EXACT;
         sel_width  = ex_w_ff;
         sel_height = ex_h_ff;
      end else if (have_cover_ff) begin
         sel_how    = HOW_COVER;
         sel_width  = cv_w_ff;
         sel_height = cv_h_ff;
      end else if (have_scale_ff) begin
         sel_how    = HOW_SCALE;
         sel_width  = sc_w_ff;
         sel_height = sc_h_ff;
      end
   end

   assign stat.done  = x_v_ff & x_last_ff;
   assign stat.found = have_exact_ff | have_cover_ff | have_scale_ff;

endmodule

// ===== rtl/carrier_mode_best_fit_select.sv =====
// ----------------------------------------------------------------------------
// carrier_mode_best_fit_select: pick the best display mode for a wanted size
//
// Request channel (req_*): a write beat loads one table slot with a width,
// a height and a usable mark; a query beat gives a wanted size. Every request
// beat produces exactly one response beat (rsp_*). A write answers with an
// acknowledge (found low, zero size, how_chosen "none").
// A query returns the first exact match, else the smallest covering mode,
// else the mode of least downscale, else "not found".
//
// Sequencing: a write loads the response register in the done state, and the
// next request is taken once that load is made. A query issues the slots in
// order, drains the ranking unit and loads the response register once the
// final slot is ranked; the next request is taken after that load. Slots are
// issued with a gap between them, set by the downscale loop of the ranking
// unit (cross multiply, then compare and update); each slot passes the memory
// read, the product stage and the two ranking stages.
// A finished response sits in an output register, so the next request is
// taken while that response is still stalled by the receiver.
// Reset clears all usable marks; widths and heights live in a memory without reset.
// ----------------------------------------------------------------------------
module carrier_mode_best_fit_select #(
   parameter int MODE_SLOTS = cmbfs_pkg::MODE_SLOTS_DEF,
   parameter int DIM_BITS   = cmbfs_pkg::DIM_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [cmbfs_pkg::SLOT_BITS-1:0] req_slot,
   input  logic [DIM_BITS-1:0]           req_width,
   input  logic [DIM_BITS-1:0]           req_height,
   input  logic                          req_entry_valid,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [DIM_BITS-1:0]           rsp_carrier_width,
   output logic [DIM_BITS-1:0]           rsp_carrier_height,
   output logic [1:0]                    rsp_how_chosen
);
   import cmbfs_pkg::*;

   localparam int IDX_W = (MODE_SLOTS > 1) ? $clog2(MODE_SLOTS) : 1;
   localparam int PW    = 2 * DIM_BITS;

   // Mode memory: width in the upper half, height in the lower half.
   logic [PW-1:0]       mode_dim_mem [MODE_SLOTS];
   logic                mark_ff      [MODE_SLOTS];

   fsm_state_type       state_ff;
   fsm_state_type       state_in;

   logic                req_accept;
   logic                wr_en;
   logic [8:0]          wr_slot_ext;
   logic [IDX_W-1:0]    wr_idx;

   logic                op_ff;
   logic [DIM_BITS-1:0] q_w_ff;
   logic [DIM_BITS-1:0] q_h_ff;

   // Scan sequencer.
   logic [IDX_W-1:0]    scan_idx_ff;
   logic                gap_ff;
   logic                issue;
   logic                issue_last;

   // Read stage.
   logic                s1_v_ff;
   logic                s1_last_ff;
   logic [PW-1:0]       rd_dim_ff;
   logic                rd_mark_ff;
   logic [DIM_BITS-1:0] rd_w;
   logic [DIM_BITS-1:0] rd_h;

   // Product stage.
   logic                s2_v_ff;
   logic                s2_last_ff;
   logic                p_use_ff;
   logic [DIM_BITS-1:0] p_w_ff;
   logic [DIM_BITS-1:0] p_h_ff;
   logic [PW-1:0]       p_area_ff;
   logic [PW-1:0]       p_a_ff;
   logic [PW-1:0]       p_b_ff;

   // Candidate presented to the ranking unit.
   logic [PW-1:0]       cand_num;
   logic                cand_exact;
   logic                cand_cover;
   rank_ctl_type        rank_ctl;
   rank_stat_type       rank_stat;
   how_type             sel_how;
   logic [DIM_BITS-1:0] sel_width;
   logic [DIM_BITS-1:0] sel_height;

   // Response register.
   logic                rsp_load;
   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [DIM_BITS-1:0] rsp_w_ff;
   logic [DIM_BITS-1:0] rsp_h_ff;
   logic [1:0]          rsp_how_ff;

   // Request handshake and write decode; slots beyond the table are dropped.
   always_comb begin
      req_accept  = req_valid && !req_stall;
      wr_slot_ext = 9'(req_slot);
      wr_idx      = wr_slot_ext[IDX_W-1:0];
      wr_en       = req_accept && (req_opcode == OP_WRITE) &&
                    (wr_slot_ext < 9'(MODE_SLOTS));
      issue       = (state_ff == ST_SCAN) && !gap_ff;
      issue_last  = issue && (scan_idx_ff == IDX_W'(MODE_SLOTS - 1));
      rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and request stall.
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_accept) begin
               state_in = (req_opcode == OP_QUERY) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rank_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Request capture and scan counters.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_opcode;
         q_w_ff <= req_width;
         q_h_ff <= req_height;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         gap_ff      <= 1'b0;
      end else if (req_accept) begin
         scan_idx_ff <= '0;
         gap_ff      <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         gap_ff <= ~gap_ff;
         if (issue && !issue_last) begin
            scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         end
      end
   end

   // Usable marks, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MODE_SLOTS; i++) begin
            mark_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         mark_ff[wr_idx] <= req_entry_valid;
      end
   end

   // Dimension memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mode_dim_mem[wr_idx] <= {req_width, req_height};
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_dim_ff  <= mode_dim_mem[scan_idx_ff];
         rd_mark_ff <= mark_ff[scan_idx_ff];
      end
   end

   // Pipeline valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         s1_last_ff <= 1'b0;
         s2_v_ff    <= 1'b0;
         s2_last_ff <= 1'b0;
      end else begin
         s1_v_ff    <= issue;
         s1_last_ff <= issue_last;
         s2_v_ff    <= s1_v_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   assign rd_w = rd_dim_ff[PW-1:DIM_BITS];
   assign rd_h = rd_dim_ff[DIM_BITS-1:0];

   // Area and the two ratio numerators of the slot just read.
   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         p_use_ff  <= rd_mark_ff && (rd_w != '0) && (rd_h != '0);
         p_w_ff    <= rd_w;
         p_h_ff    <= rd_h;
         p_area_ff <= PW'(rd_w) * PW'(rd_h);
         p_a_ff    <= PW'(q_w_ff) * PW'(rd_h);
         p_b_ff    <= PW'(q_h_ff) * PW'(rd_w);
      end
   end

   // Downscale numerator and the exact and covering tests.
   always_comb begin
      cand_num        = (p_a_ff > p_b_ff) ? p_a_ff : p_b_ff;
      cand_exact      = (p_w_ff == q_w_ff) && (p_h_ff == q_h_ff);
      cand_cover      = (p_w_ff >= q_w_ff) && (p_h_ff >= q_h_ff);
      rank_ctl.start  = req_accept && (req_opcode == OP_QUERY);
      rank_ctl.take   = s2_v_ff;
      rank_ctl.last   = s2_last_ff;
   end

   cmbfs_rank #(
      .DIM_BITS (DIM_BITS)
   ) u_rank (
      .clock       (clock),
      .reset       (reset),
      .ctl         (rank_ctl),
      .cand_use    (p_use_ff),
      .cand_exact  (cand_exact),
      .cand_cover  (cand_cover),
      .cand_width  (p_w_ff),
      .cand_height (p_h_ff),
      .cand_area   (p_area_ff),
      .cand_num    (cand_num),
      .stat        (rank_stat),
      .sel_how     (sel_how),
      .sel_width   (sel_width),
      .sel_height  (sel_height)
   );

   // Response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload: write acknowledge or the chosen mode.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (op_ff == OP_WRITE) begin
            rsp_found_ff <= 1'b0;
            rsp_w_ff     <= '0;
            rsp_h_ff     <= '0;
            rsp_how_ff   <= HOW_NONE;
         end else begin
            rsp_found_ff <= rank_stat.found;
            rsp_w_ff     <= sel_width;
            rsp_h_ff     <= sel_height;
            rsp_how_ff   <= sel_how;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_carrier_width  = rsp_w_ff;
   assign rsp_carrier_height = rsp_h_ff;
   assign rsp_how_chosen     = rsp_how_ff;

endmodule

// ===== rtl/cmbfs_check.sv =====
// ----------------------------------------------------------------------------
// cmbfs_check: port-level checks for the carrier mode best-fit selector
// Watches the response channel for a held payload under stall and for
// consistency between the found flag, the chosen rule and the mode size.
// ----------------------------------------------------------------------------
module cmbfs_check #(
   parameter int DIM_BITS = cmbfs_pkg::DIM_BITS_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic                rsp_found,
   input logic [DIM_BITS-1:0] rsp_carrier_width,
   input logic [DIM_BITS-1:0] rsp_carrier_height,
   input logic [1:0]          rsp_how_chosen
);
   import cmbfs_pkg::*;

   // A stalled response beat stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_carrier_width) && $stable(rsp_carrier_height) &&
      $stable(rsp_how_chosen))
      else $error("stalled response beat changed");

   // The found flag agrees with the reported rule.
   a_found_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == (rsp_how_chosen != HOW_NONE)))
      else $error("found flag disagrees with how_chosen");

   // A miss or an acknowledge carries a zero size.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_carrier_width == '0) &&
      (rsp_carrier_height == '0))
      else $error("nonzero size without a found mode");

   // A zero-sized mode is never chosen.
   a_found_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> (rsp_carrier_width != '0) &&
      (rsp_carrier_height != '0))
      else $error("zero-sized mode returned");

endmodule

bind carrier_mode_best_fit_select cmbfs_check #(
   .DIM_BITS (DIM_BITS)
) u_cmbfs_check (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_found          (rsp_found),
   .rsp_carrier_width  (rsp_carrier_width),
   .rsp_carrier_height (rsp_carrier_height),
   .rsp_how_chosen     (rsp_how_chosen)
);
